// ----- rtl/eqh_pkg.sv -----
`default_nettype none
package eqh_pkg;

   localparam int ANGLE_BITS = 32;
   localparam int STEPS = 31;

   // Sine and cosine values are signed Q30.
   localparam int Q_W = 32;
   localparam logic signed [Q_W-1:0] Q_ONE = 32'sd1073741824;

   // Datapath widths of the rotation and vectoring pipelines.
   localparam int ROT_W = 34;
   localparam int ROT_ZW = 33;
   localparam int VEC_IN_W = 34;
   localparam int VEC_W = 36;
   localparam int VEC_ZW = 34;

   localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
   localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [31:0] HALF_TURN = 32'h8000_0000;

   // Pipeline depths, counted in register levels.
   localparam int ROT_LAT = STEPS + 2;
   localparam int MUL_LAT = 3;
   localparam int VEC_LAT = STEPS + 2;
   localparam int TOTAL_LAT = ROT_LAT + MUL_LAT + 2 * VEC_LAT + 1;

   localparam logic [31:0] STEP_ANGLE [0:STEPS-1] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1
   };

endpackage
`default_nettype wire

// ----- rtl/eqh_rotate.sv -----
`default_nettype none
// Pipelined rotation-mode CORDIC: one micro-rotation per stage, sine and
// cosine in Q30, saturated to plus or minus one.
module eqh_rotate (
   input  wire                                  clock,
   input  wire  [31:0]                          angle,
   output logic signed [eqh_pkg::Q_W-1:0]       sin_q,
   output logic signed [eqh_pkg::Q_W-1:0]       cos_q
);

   logic signed [eqh_pkg::ROT_W-1:0]  x_ff [0:eqh_pkg::STEPS];
   logic signed [eqh_pkg::ROT_W-1:0]  y_ff [0:eqh_pkg::STEPS];
   logic signed [eqh_pkg::ROT_ZW-1:0] z_ff [0:eqh_pkg::STEPS];
   logic [eqh_pkg::STEPS:0]           flip_ff;

   logic [31:0] sum_in;
   logic [31:0] fold_in;
   logic signed [eqh_pkg::ROT_W-1:0] xo_in, yo_in;
   logic signed [eqh_pkg::Q_W-1:0]   sin_ff, cos_ff, sin_in, cos_in;

   // Angles in the left half plane are turned by a half turn first.
   always_comb begin
      sum_in  = angle + eqh_pkg::QUARTER_TURN;
      fold_in = sum_in[31] ? angle + eqh_pkg::HALF_TURN : angle;
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= eqh_pkg::ROT_W'(eqh_pkg::GAIN_Q30);
      y_ff[0]    <= '0;
      z_ff[0]    <= eqh_pkg::ROT_ZW'($signed(fold_in));
      flip_ff[0] <= sum_in[31];
   end

   for (genvar i = 0; i < eqh_pkg::STEPS; i++) begin : g_step
      logic signed [eqh_pkg::ROT_W-1:0]  x_in, y_in;
      logic signed [eqh_pkg::ROT_ZW-1:0] z_in;
      always_comb begin
         if (z_ff[i] >= 0) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - eqh_pkg::ROT_ZW'(eqh_pkg::STEP_ANGLE[i]);
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + eqh_pkg::ROT_ZW'(eqh_pkg::STEP_ANGLE[i]);
         end
      end
      always_ff @(posedge clock) begin
         x_ff[i+1]    <= x_in;
         y_ff[i+1]    <= y_in;
         z_ff[i+1]    <= z_in;
         flip_ff[i+1] <= flip_ff[i];
      end
   end

   always_comb begin
      xo_in = flip_ff[eqh_pkg::STEPS] ? -x_ff[eqh_pkg::STEPS] : x_ff[eqh_pkg::STEPS];
      yo_in = flip_ff[eqh_pkg::STEPS] ? -y_ff[eqh_pkg::STEPS] : y_ff[eqh_pkg::STEPS];
      if (xo_in > eqh_pkg::ROT_W'(eqh_pkg::Q_ONE))
         cos_in = eqh_pkg::Q_ONE;
      else if (xo_in < -eqh_pkg::ROT_W'(eqh_pkg::Q_ONE))
         cos_in = -eqh_pkg::Q_ONE;
      else
         cos_in = xo_in[eqh_pkg::Q_W-1:0];
      if (yo_in > eqh_pkg::ROT_W'(eqh_pkg::Q_ONE))
         sin_in = eqh_pkg::Q_ONE;
      else if (yo_in < -eqh_pkg::ROT_W'(eqh_pkg::Q_ONE))
         sin_in = -eqh_pkg::Q_ONE;
      else
         sin_in = yo_in[eqh_pkg::Q_W-1:0];
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign sin_q = sin_ff;
   assign cos_q = cos_ff;

endmodule
`default_nettype wire

// ----- rtl/eqh_vector.sv -----
`default_nettype none
// Pipelined vectoring-mode CORDIC: angle of (x, y) in turn units and the
// gain-corrected magnitude. The zero vector gives angle 0 and magnitude 0.
module eqh_vector (
   input  wire                                    clock,
   input  wire  signed [eqh_pkg::VEC_IN_W-1:0]    x_in_q,
   input  wire  signed [eqh_pkg::VEC_IN_W-1:0]    y_in_q,
   output logic signed [eqh_pkg::VEC_ZW-1:0]      angle,
   output logic signed [eqh_pkg::VEC_IN_W-1:0]    magnitude
);

   localparam int PROD_W = eqh_pkg::VEC_W + 31;

   logic signed [eqh_pkg::VEC_W-1:0]  x_ff [0:eqh_pkg::STEPS];
   logic signed [eqh_pkg::VEC_W-1:0]  y_ff [0:eqh_pkg::STEPS];
   logic signed [eqh_pkg::VEC_ZW-1:0] z_ff [0:eqh_pkg::STEPS];
   logic [eqh_pkg::STEPS:0]           zero_ff;

   logic signed [eqh_pkg::VEC_W-1:0]    xe_in, ye_in;
   logic signed [PROD_W-1:0]            prod_in;
   logic signed [eqh_pkg::VEC_ZW-1:0]   angle_ff;
   logic signed [eqh_pkg::VEC_IN_W-1:0] mag_ff;

   always_comb begin
      xe_in = eqh_pkg::VEC_W'(x_in_q);
      ye_in = eqh_pkg::VEC_W'(y_in_q);
   end

   // A vector in the left half plane is turned by a half turn first.
   always_ff @(posedge clock) begin
      zero_ff[0] <= (x_in_q == '0) && (y_in_q == '0);
      if (x_in_q < 0) begin
         x_ff[0] <= -xe_in;
         y_ff[0] <= -ye_in;
         z_ff[0] <= eqh_pkg::VEC_ZW'({1'b0, eqh_pkg::HALF_TURN});
      end else begin
         x_ff[0] <= xe_in;
         y_ff[0] <= ye_in;
         z_ff[0] <= '0;
      end
   end

   for (genvar i = 0; i < eqh_pkg::STEPS; i++) begin : g_step
      logic signed [eqh_pkg::VEC_W-1:0]  x_in, y_in;
      logic signed [eqh_pkg::VEC_ZW-1:0] z_in;
      always_comb begin
         if (y_ff[i] > 0) begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + eqh_pkg::VEC_ZW'(eqh_pkg::STEP_ANGLE[i]);
         end else begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - eqh_pkg::VEC_ZW'(eqh_pkg::STEP_ANGLE[i]);
         end
      end
      always_ff @(posedge clock) begin
         x_ff[i+1]    <= x_in;
         y_ff[i+1]    <= y_in;
         z_ff[i+1]    <= z_in;
         zero_ff[i+1] <= zero_ff[i];
      end
   end

   assign prod_in = PROD_W'(x_ff[eqh_pkg::STEPS]) * PROD_W'(eqh_pkg::GAIN_Q30);

   always_ff @(posedge clock) begin
      if (zero_ff[eqh_pkg::STEPS]) begin
         angle_ff <= '0;
         mag_ff   <= '0;
      end else begin
         angle_ff <= z_ff[eqh_pkg::STEPS];
         mag_ff   <= prod_in[30 +: eqh_pkg::VEC_IN_W];
      end
   end

   assign angle     = angle_ff;
   assign magnitude = mag_ff;

endmodule
`default_nettype wire

// ----- rtl/equatorial_to_horizontal.sv -----
`default_nettype none
// Equatorial to horizontal transform. Each item carries an hour angle and a
// declination in binary angle units (2^32 per turn) and yields one result with
// the azimuth, counted eastward from north, and the signed altitude. The
// observer latitude is written through csr_we and csr_wdata, and the user must
// write it only while no item is in flight; the block itself leaves this
// unchecked. The block is a fully pipelined datapath: busy never rises, a new
// item may start in every cycle, and each result sits on the rsp_ ports for
// one cycle with rsp_valid high. The receiver cannot stall the pipeline, so
// it must take every strobe. The depth comes from three parallel 31-step sine
// and cosine CORDIC pipelines, two product stages and a sum stage, two chained
// 31-step vectoring CORDIC pipelines (one for azimuth and horizontal magnitude,
// one for altitude), and the output register.
module equatorial_to_horizontal (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire  [31:0] req_hour_angle,
   input  wire  [31:0] req_declination,
   output logic        rsp_valid,
   output logic [31:0] rsp_azimuth,
   output logic [31:0] rsp_altitude,
   input  wire         csr_we,
   input  wire  [31:0] csr_wdata
);

   localparam int QW = eqh_pkg::Q_W;
   localparam int VW = eqh_pkg::VEC_IN_W;
   localparam int ZW = eqh_pkg::VEC_ZW;
   localparam int DLY = eqh_pkg::VEC_LAT;

   // Latitude register.
   logic [31:0] latitude_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         latitude_ff <= '0;
      end else if (csr_we) begin
         latitude_ff <= csr_wdata;
      end
   end

   // Valid bits travel beside the data; one bit per register level.
   logic                          accept_in;
   logic [eqh_pkg::TOTAL_LAT-1:0] valid_ff;

   assign busy      = 1'b0;
   assign accept_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[eqh_pkg::TOTAL_LAT-2:0], accept_in};
      end
   end

   // Sines and cosines of hour angle, declination and latitude.
   logic signed [QW-1:0] sh, ch, sd, cd, sp, cp;

   eqh_rotate u_rot_ha  (.clock(clock), .angle(req_hour_angle),  .sin_q(sh), .cos_q(ch));
   eqh_rotate u_rot_dec (.clock(clock), .angle(req_declination), .sin_q(sd), .cos_q(cd));
   eqh_rotate u_rot_lat (.clock(clock), .angle(latitude_ff),     .sin_q(sp), .cos_q(cp));

   // First product stage: every Q30 product is floored back to Q30.
   logic signed [2*QW-1:0] ya_in, p1_in, p2_in, p3_in, p4_in;
   logic signed [QW-1:0]   ya_ff, p1_ff, p2_ff, p3_ff, p4_ff, cd_ff, ch_ff;

   always_comb begin
      ya_in = (sh * cd) >>> 30;
      p1_in = (ch * sp) >>> 30;
      p2_in = (sd * cp) >>> 30;
      p3_in = (sp * sd) >>> 30;
      p4_in = (cp * cd) >>> 30;
   end

   always_ff @(posedge clock) begin
      ya_ff <= ya_in[QW-1:0];
      p1_ff <= p1_in[QW-1:0];
      p2_ff <= p2_in[QW-1:0];
      p3_ff <= p3_in[QW-1:0];
      p4_ff <= p4_in[QW-1:0];
      cd_ff <= cd;
      ch_ff <= ch;
   end

   // Second product stage.
   logic signed [2*QW-1:0] q1_in, q2_in;
   logic signed [QW-1:0]   q1_ff, q2_ff, ya2_ff, p2b_ff, p3b_ff;

   always_comb begin
      q1_in = (p1_ff * cd_ff) >>> 30;
      q2_in = (p4_ff * ch_ff) >>> 30;
   end

   always_ff @(posedge clock) begin
      q1_ff  <= q1_in[QW-1:0];
      q2_ff  <= q2_in[QW-1:0];
      ya2_ff <= ya_ff;
      p2b_ff <= p2_ff;
      p3b_ff <= p3_ff;
   end

   // Sum stage: horizontal vector (xa, ya) and vertical component v.
   logic signed [VW-1:0] xa_ff, ya3_ff, v_ff;

   always_ff @(posedge clock) begin
      xa_ff  <= VW'(q1_ff) - VW'(p2b_ff);
      ya3_ff <= VW'(ya2_ff);
      v_ff   <= VW'(p3b_ff) + VW'(q2_ff);
   end

   // The vertical component waits while the horizontal vector is measured.
   logic signed [VW-1:0] v_dly_ff [0:DLY-1];

   always_ff @(posedge clock) begin
      v_dly_ff[0] <= v_ff;
      for (int k = 1; k < DLY; k++) begin
         v_dly_ff[k] <= v_dly_ff[k-1];
      end
   end

   // Azimuth angle and horizontal magnitude.
   logic signed [ZW-1:0] az_angle;
   logic signed [VW-1:0] r_mag;

   eqh_vector u_vec_az (
      .clock(clock), .x_in_q(xa_ff), .y_in_q(ya3_ff),
      .angle(az_angle), .magnitude(r_mag)
   );

   // Azimuth is measured from north, so a half turn is taken off; it then
   // waits for the altitude pipeline.
   logic [31:0] az_dly_ff [0:DLY-1];
   logic [ZW-1:0] az_sum_in;

   assign az_sum_in = az_angle - ZW'({1'b0, eqh_pkg::HALF_TURN});

   always_ff @(posedge clock) begin
      az_dly_ff[0] <= az_sum_in[31:0];
      for (int k = 1; k < DLY; k++) begin
         az_dly_ff[k] <= az_dly_ff[k-1];
      end
   end

   // Altitude is the angle of (r, v); r is never negative.
   logic signed [ZW-1:0] alt_angle;
   logic signed [VW-1:0] alt_mag;

   eqh_vector u_vec_alt (
      .clock(clock), .x_in_q(r_mag), .y_in_q(v_dly_ff[DLY-1]),
      .angle(alt_angle), .magnitude(alt_mag)
   );

   // Output register; the altitude is held within a quarter turn.
   logic [31:0] az_out_ff, alt_out_ff, alt_in;

   always_comb begin
      if (alt_angle > ZW'(eqh_pkg::Q_ONE))
         alt_in = eqh_pkg::QUARTER_TURN;
      else if (alt_angle < -ZW'(eqh_pkg::Q_ONE))
         alt_in = -eqh_pkg::QUARTER_TURN;
      else
         alt_in = alt_angle[31:0];
   end

   always_ff @(posedge clock) begin
      az_out_ff  <= az_dly_ff[DLY-1];
      alt_out_ff <= alt_in;
   end

   assign rsp_valid    = valid_ff[eqh_pkg::TOTAL_LAT-1];
   assign rsp_azimuth  = az_out_ff;
   assign rsp_altitude = alt_out_ff;

`ifndef SYNTHESIS
   localparam int SUM_IDX = eqh_pkg::ROT_LAT + eqh_pkg::MUL_LAT - 1;
   localparam int R_IDX = SUM_IDX + eqh_pkg::VEC_LAT;

   a_alt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_altitude) <= $signed(eqh_pkg::QUARTER_TURN)
                     && $signed(rsp_altitude) >= -$signed(eqh_pkg::QUARTER_TURN)))
      else $error("altitude outside a quarter turn");

   a_mag_sign: assert property (@(posedge clock) disable iff (reset)
      valid_ff[R_IDX] |-> (r_mag >= 0))
      else $error("horizontal magnitude negative");

   a_xa_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[SUM_IDX] |-> (xa_ff <= VW'(34'sd2147483648) && xa_ff >= -VW'(34'sd2147483648)))
      else $error("horizontal component out of range");

   a_alt_mag: assert property (@(posedge clock) disable iff (reset)
      valid_ff[eqh_pkg::TOTAL_LAT-2] |-> (alt_mag >= 0))
      else $error("altitude vector magnitude negative");
`endif

endmodule
`default_nettype wire

// ----- dv/tb_equatorial_to_horizontal.sv -----
`timescale 1ns / 100ps
module tb_equatorial_to_horizontal;

   // One predicted result: the horizontal direction of a star.
   typedef struct packed {
      logic [31:0] azimuth;
      logic [31:0] altitude;
   } horiz_dir_type;

   // The pointing scoreboard keeps its own copy of the observer latitude and
   // computes the expected azimuth and altitude of every accepted item with
   // the same integer CORDIC arithmetic that the block is meant to use.
   class pointing_scoreboard;
      logic [31:0] obs_latitude;
      horiz_dir_type pending_dirs[$];
      int mismatches;

      function new();
         obs_latitude = '0;
         pending_dirs = {};
         mismatches = 0;
      endfunction

      function longint clamp_q30(longint v);
         if (v > longint'(eqh_pkg::Q_ONE)) return longint'(eqh_pkg::Q_ONE);
         if (v < -longint'(eqh_pkg::Q_ONE)) return -longint'(eqh_pkg::Q_ONE);
         return v;
      endfunction

      // Rotation-mode CORDIC after a half-turn fold into [-1/4, +1/4) turn.
      function void rotate_unit(input logic [31:0] ang, output longint s_q,
                                output longint c_q);
         logic [31:0] probe;
         logic flip;
         longint x, y, z, nx;
         probe = ang + eqh_pkg::QUARTER_TURN;
         flip = probe[31];
         if (flip) ang = ang + eqh_pkg::HALF_TURN;
         x = longint'(eqh_pkg::GAIN_Q30);
         y = 0;
         z = longint'($signed(ang));
         for (int i = 0; i < eqh_pkg::STEPS; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z = z - longint'(eqh_pkg::STEP_ANGLE[i]);
            end else begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z = z + longint'(eqh_pkg::STEP_ANGLE[i]);
            end
            x = nx;
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         c_q = clamp_q30(x);
         s_q = clamp_q30(y);
      endfunction

      // Vectoring-mode CORDIC: angle of (x, y) and its length. The zero
      // vector gives angle zero and length zero.
      function longint vector_dir(input longint x, input longint y,
                                  output longint len);
         longint z, nx;
         z = 0;
         if (x == 0 && y == 0) begin
            len = 0;
            return 0;
         end
         if (x < 0) begin
            x = -x;
            y = -y;
            z = longint'(eqh_pkg::HALF_TURN);
         end
         for (int i = 0; i < eqh_pkg::STEPS; i++) begin
            if (y > 0) begin
               nx = x + (y >>> i);
               y = y - (x >>> i);
               z = z + longint'(eqh_pkg::STEP_ANGLE[i]);
            end else begin
               nx = x - (y >>> i);
               y = y + (x >>> i);
               z = z - longint'(eqh_pkg::STEP_ANGLE[i]);
            end
            x = nx;
         end
         len = (x * longint'(eqh_pkg::GAIN_Q30)) >>> 30;
         return z;
      endfunction

      function void set_latitude(logic [31:0] lat);
         obs_latitude = lat;
      endfunction

      function void note_item(logic [31:0] ha, logic [31:0] dec);
         longint sh, ch, sd, cd, sp, cp, ya, xa, hlen, vz, az, alt, dummy;
         horiz_dir_type dir;
         rotate_unit(ha, sh, ch);
         rotate_unit(dec, sd, cd);
         rotate_unit(obs_latitude, sp, cp);
         ya = (sh * cd) >>> 30;
         xa = (((ch * sp) >>> 30) * cd >>> 30) - ((sd * cp) >>> 30);
         az = vector_dir(xa, ya, hlen) - longint'(eqh_pkg::HALF_TURN);
         vz = ((sp * sd) >>> 30) + ((((cp * cd) >>> 30) * ch) >>> 30);
         alt = clamp_q30(vector_dir(hlen, vz, dummy));
         dir.azimuth = az[31:0];
         dir.altitude = alt[31:0];
         pending_dirs.push_back(dir);
      endfunction

      function void check_result(logic [31:0] az, logic [31:0] alt);
         horiz_dir_type want;
         if (pending_dirs.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: azimuth %h altitude %h", az, alt);
            return;
         end
         want = pending_dirs.pop_front();
         if (az !== want.azimuth || alt !== want.altitude) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: azimuth %h (want %h) altitude %h (want %h)",
                        az, want.azimuth, alt, want.altitude);
         end
      endfunction

      function int pending();
         return pending_dirs.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_hour_angle;
   logic [31:0] req_declination;
   logic        rsp_valid;
   logic [31:0] rsp_azimuth;
   logic [31:0] rsp_altitude;
   logic        csr_we;
   logic [31:0] csr_wdata;

   pointing_scoreboard board;

   equatorial_to_horizontal uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_hour_angle (req_hour_angle),
      .req_declination(req_declination),
      .rsp_valid      (rsp_valid),
      .rsp_azimuth    (rsp_azimuth),
      .rsp_altitude   (rsp_altitude),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // The monitor runs at the rising edge and sees the values that were
   // present just before it, since every signal changes by nonblocking
   // assignment. A latitude write updates the scoreboard at the same edge
   // at which the block takes it.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) board.set_latitude(csr_wdata);
         if (start && !busy) board.note_item(req_hour_angle, req_declination);
         if (rsp_valid) board.check_result(rsp_azimuth, rsp_altitude);
      end
   end

   // Offers one item and returns at the edge where the block accepts it.
   // Start is left high, so a following item keeps it high without a glitch.
   task automatic send_item(logic [31:0] ha, logic [31:0] dec);
      start <= 1'b1;
      req_hour_angle <= ha;
      req_declination <= dec;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic idle_cycles(int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Holds off the sender until every predicted result has come back, then
   // idles further so the pipeline is surely empty.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (board.pending() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_latitude(logic [31:0] lat);
      csr_we <= 1'b1;
      csr_wdata <= lat;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Declination within its legal range of plus or minus a quarter turn.
   function automatic logic [31:0] rand_dec();
      longint v;
      v = longint'($urandom_range(32'h8000_0000, 0)) - 64'sh4000_0000;
      return v[31:0];
   endfunction

   // Random items in bursts of random length with random gaps; some bursts
   // run with no gap at all so that back-to-back starts are exercised.
   task automatic random_items(int count);
      int sent;
      int burst;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(20, 1);
         for (int k = 0; k < burst && sent < count; k++) begin
            if ($urandom_range(5, 0) == 0)
               send_item($urandom, $urandom_range(1, 0) ? 32'h4000_0000 : 32'hC000_0000);
            else
               send_item($urandom, rand_dec());
            sent++;
         end
         if ($urandom_range(3, 0) != 0) idle_cycles($urandom_range(12, 1));
      end
   endtask

   logic [31:0] lat_plan[6];

   initial begin
      board = new();
      reset <= 1'b1;
      start <= 1'b0;
      req_hour_angle <= '0;
      req_declination <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at the reset latitude of zero: field extremes, the
      // celestial poles and the cardinal hour angles.
      send_item(32'h0000_0000, 32'h0000_0000);
      send_item(32'hFFFF_FFFF, 32'h0000_0000);
      send_item(32'h4000_0000, 32'h0000_0000);
      send_item(32'h8000_0000, 32'h0000_0000);
      send_item(32'hC000_0000, 32'h0000_0000);
      send_item(32'h0000_0000, 32'h4000_0000);
      send_item(32'h1234_5678, 32'hC000_0000);
      send_item(32'hFFFF_FFFF, 32'h3FFF_FFFF);
      send_item(32'h8000_0001, 32'hC000_0001);
      send_item(32'h2000_0000, 32'h2000_0000);
      send_item(32'hE000_0000, 32'hE000_0000);
      drain();

      // At the north pole of the observer the zenith is the celestial pole.
      write_latitude(32'h4000_0000);
      send_item(32'h0000_0000, 32'h4000_0000);
      send_item(32'h8000_0000, 32'h0000_0000);
      send_item(32'h7FFF_FFFF, 32'hC000_0000);
      drain();
      write_latitude(32'hC000_0000);
      send_item(32'h0000_0000, 32'hC000_0000);
      send_item(32'h4000_0000, 32'h4000_0000);
      send_item(32'hFFFF_FFFF, 32'h0000_0000);
      drain();

      // Random phases at several latitudes, the extremes among them.
      lat_plan[0] = 32'h0000_0000;
      lat_plan[1] = 32'h4000_0000;
      lat_plan[2] = 32'hC000_0000;
      lat_plan[3] = rand_dec();
      lat_plan[4] = rand_dec();
      lat_plan[5] = 32'h1C71_C71C;
      foreach (lat_plan[p]) begin
         write_latitude(lat_plan[p]);
         random_items(65);
         drain();
      end

      drain();
      repeat (120) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0)
         $display("tb_equatorial_to_horizontal OK");
      else
         $display("tb_equatorial_to_horizontal NOT OK");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("tb_equatorial_to_horizontal NOT OK");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/eqh_pkg.sv
rtl/eqh_rotate.sv
rtl/eqh_vector.sv
rtl/equatorial_to_horizontal.sv
dv/tb_equatorial_to_horizontal.sv
